[design/sorted_insertion_queue_assert.svh]
// Assertion macros shared by the sorted insertion queue RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef SORTED_INSERTION_QUEUE_ASSERT_SVH
`define SORTED_INSERTION_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SIQ_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define SIQ_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

[design/siq_pkg.sv]
// Shared types for the sorted insertion queue.
// Command and status bundles between siq_ctrl and siq_datapath.
package siq_pkg;

    typedef struct packed {
        logic insert;
        logic rotate;
    } siq_cmd_t;

    typedef struct packed {
        logic full;
        logic last_elem;
    } siq_status_t;

endpackage

[design/siq_datapath.sv]
// Datapath of the sorted insertion queue: a row of ordered cells, fill count
// and list index. Depends on siq_pkg and sorted_insertion_queue_assert.svh.
`include "sorted_insertion_queue_assert.svh"

module siq_datapath
    import siq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic signed [31:0] new_value,
    input  siq_cmd_t           cmd,
    output siq_status_t        stat,
    output logic signed [31:0] front
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    logic signed [31:0] cell_reg  [DEPTH];
    logic signed [31:0] cell_next [DEPTH];
    logic [DEPTH-1:0]   less;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [CW-1:0]      count_m1;
    logic [IW-1:0]      idx_reg;
    logic [IW-1:0]      idx_next;

    assign count_m1 = count_reg - CW'(1);

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        assign less[i] = (CW'(i) < count_reg) && (cell_reg[i] < new_value);

        always_comb
        begin
            cell_next[i] = cell_reg[i];
            if (cmd.insert && !less[i])
            begin
                if (i == 0)
                    cell_next[i] = new_value;
                else if (less[(i == 0) ? 0 : i - 1])
                    cell_next[i] = new_value;
                else
                    cell_next[i] = cell_reg[(i == 0) ? 0 : i - 1];
            end
            else if (cmd.rotate)
            begin
                if (i == DEPTH - 1 || CW'(i) == count_m1)
                    cell_next[i] = cell_reg[0];
                else
                    cell_next[i] = cell_reg[(i == DEPTH - 1) ? i : i + 1];
            end
        end

        always_ff @(posedge clk)
        begin
            cell_reg[i] <= cell_next[i];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        idx_next   = idx_reg;
        if (cmd.insert)
        begin
            count_next = count_reg + CW'(1);
            idx_next   = '0;
        end
        else if (cmd.rotate)
        begin
            idx_next = idx_reg + IW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    assign stat.full      = (count_reg == CW'(DEPTH));
    assign stat.last_elem = (CW'(idx_reg) == count_m1);
    assign front          = cell_reg[0];

    `SIQ_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(DEPTH), "count overflow")
    `SIQ_ASSERT_NOW(a_insert_room, clk, rst_n, cmd.insert, !stat.full && !cmd.rotate, "bad insert")
    `SIQ_ASSERT_NEXT(a_count_step, clk, rst_n, cmd.insert, count_reg == $past(count_reg) + CW'(1), "no step")
    `SIQ_ASSERT_NOW(a_rotate_nonempty, clk, rst_n, cmd.rotate, count_reg != '0, "empty listing")

endmodule

[design/siq_ctrl.sv]
// Controller of the sorted insertion queue: accept, listing and refusal states.
// Depends on siq_pkg and sorted_insertion_queue_assert.svh.
`include "sorted_insertion_queue_assert.svh"

module siq_ctrl
    import siq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    output logic        out_valid,
    input  logic        out_stall,
    input  siq_status_t stat,
    output siq_cmd_t    cmd,
    output logic        refused,
    output logic        last
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_LIST = 3'b010,
        ST_FULL = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_take;
    logic   out_take;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_valid = (state_reg == ST_LIST) || (state_reg == ST_FULL);
    assign out_take  = out_valid && !out_stall;

    assign cmd.insert = in_take && !stat.full;
    assign cmd.rotate = (state_reg == ST_LIST) && out_take;
    assign refused    = (state_reg == ST_FULL);
    assign last       = refused || stat.last_elem;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                    state_next = stat.full ? ST_FULL : ST_LIST;
            end
            ST_LIST:
            begin
                if (out_take && stat.last_elem)
                    state_next = ST_IDLE;
            end
            ST_FULL:
            begin
                if (out_take)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    `SIQ_ASSERT_NOW(a_no_overlap, clk, rst_n, out_valid, in_stall, "request accepted while results pending")
    `SIQ_ASSERT_NEXT(a_refuse_path, clk, rst_n, in_take && stat.full, state_reg == ST_FULL, "full queue not refused")
    `SIQ_ASSERT_NEXT(a_list_path, clk, rst_n, in_take && !stat.full, state_reg == ST_LIST, "insert not followed by listing")

endmodule

[design/sorted_insertion_queue.sv]
// Sorted insertion queue: holds up to DEPTH signed 32-bit values in ascending
// order. Each request inserts one value (or is refused with a single status
// result when the queue is full) and then lists the whole queue front to back.
// Timing: when a request is taken, the value is placed by a parallel
// compare-and-shift across the cell row; then n results follow, one per cycle
// while out_stall is low, with n the fill after insertion, read from the front
// of the row as it rotates. The next request can be taken in the cycle after
// the last result is taken.
// Depends on siq_pkg, siq_ctrl and siq_datapath.
module sorted_insertion_queue
    import siq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] new_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] listed_value,
    output logic               status,
    output logic               last
);

    siq_cmd_t           cmd;
    siq_status_t        stat;
    logic signed [31:0] front;
    logic               refused;

    siq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd),
        .refused   (refused),
        .last      (last)
    );

    siq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .new_value (new_value),
        .cmd       (cmd),
        .stat      (stat),
        .front     (front)
    );

    assign status       = refused;
    assign listed_value = refused ? '0 : front;

endmodule

[tb/testbench.sv]
// Self-checking bench for sorted_insertion_queue: sorts each accepted request
// into a shadow copy of the queue and checks every listing it returns.
// Depends only on the sorted_insertion_queue RTL.
module testbench;

    localparam int QUEUE_DEPTH = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 80;
    localparam int PHASE_REQUESTS = 113;

    typedef struct {
        logic signed [31:0] listed;
        logic               full;
        logic               final_one;
    } listing_t;

    class sorted_queue_model;
        logic signed [31:0] held[$];
        listing_t           pending_listings[$];
        int                 errors;
        int                 inserts;
        int                 refusals;
        int                 checked;

        function void note_request(logic signed [31:0] v);
            int       pos;
            listing_t item;
            if (held.size() >= QUEUE_DEPTH)
            begin
                item = '{32'sd0, 1'b1, 1'b1};
                pending_listings.push_back(item);
                refusals++;
                return;
            end
            pos = held.size();
            for (int i = 0; i < held.size(); i++)
            begin
                if (!(held[i] < v))
                begin
                    pos = i;
                    break;
                end
            end
            held.insert(pos, v);
            inserts++;
            for (int i = 0; i < held.size(); i++)
            begin
                item = '{held[i], 1'b0, (i == held.size() - 1)};
                pending_listings.push_back(item);
            end
        endfunction

        function void check_listing(logic signed [31:0] v, logic s, logic l);
            listing_t want;
            if (pending_listings.size() == 0)
            begin
                $error("unexpected result: listed_value %0d status %0b last %0b", v, s, l);
                errors++;
                return;
            end
            want = pending_listings.pop_front();
            checked++;
            if (v !== want.listed)
            begin
                $error("listed_value: expected %0d, got %0d", want.listed, v);
                errors++;
            end
            if (s !== want.full)
            begin
                $error("status: expected %0b, got %0b", want.full, s);
                errors++;
            end
            if (l !== want.final_one)
            begin
                $error("last: expected %0b, got %0b", want.final_one, l);
                errors++;
            end
        endfunction

        function int pending();
            return pending_listings.size();
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic signed [31:0] new_value = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [31:0] listed_value;
    logic               status;
    logic               last;

    sorted_queue_model model = new();
    int send_idle_pct = 0;
    int stall_pct = 0;
    bit hold_req = 1'b0;
    int cycles = 0;

    sorted_insertion_queue #(.DEPTH(QUEUE_DEPTH)) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .new_value(new_value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .listed_value(listed_value),
        .status(status),
        .last(last)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver: checks results, random stall, long hold on request
    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                model.check_listing(listed_value, status, last);
            if (hold_left > 0)
                hold_left--;
            else if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            out_stall <= (hold_left > 0) || ($urandom_range(99) < stall_pct);
        end
    end

    task automatic send_request(input logic signed [31:0] v);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        new_value <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        model.note_request(v);
    endtask

    task automatic wait_drained();
        while (model.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(3))
            0: return $signed($urandom_range(40)) - 20;
            1: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return $signed($urandom);
        endcase
    endfunction

    initial
    begin : stimulus
        logic signed [31:0] directed[$];
        int idle_by_phase[4];
        int stall_by_phase[4];
        directed = '{32'sd0, 32'sh7FFF_FFFF, 32'sh8000_0000, -32'sd1, 32'sd1, 32'sd0,
                     32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh5555_5555, 32'shAAAA_AAAA,
                     32'sd100, -32'sd100, 32'sd100, 32'sd50, 32'sh7FFF_FFFE,
                     32'sh8000_0001, 32'shFFFF_FFFF, 32'sd0};
        idle_by_phase = '{0, 73, 0, 28};
        stall_by_phase = '{0, 0, 73, 28};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // hold the output so the queue backs up into the input
        hold_req = 1'b1;
        send_idle_pct = 28;
        stall_pct = 28;
        foreach (directed[i])
            send_request(directed[i]);
        in_valid <= 1'b0;
        wait_drained();

        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct = idle_by_phase[p];
            stall_pct = stall_by_phase[p];
            repeat (PHASE_REQUESTS)
                send_request(pick_value());
            in_valid <= 1'b0;
            wait_drained();
        end

        stall_pct = 0;
        repeat (24) @(posedge clk);

        $display("Ran %0d inserts and %0d refused requests, %0d results checked,",
                 model.inserts, model.refusals, model.checked);
        $display("under a long output hold and four sender/receiver pacing mixes.");
        if (model.errors == 0 && model.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[files.f]
+incdir+design
design/siq_pkg.sv
design/siq_datapath.sv
design/siq_ctrl.sv
design/sorted_insertion_queue.sv
tb/testbench.sv
